// File: hdl/byte_distribution_to_bit_predictor_top_assert.svh
// Assertion macros for the byte distribution bit predictor.
// Both macros sample on clk_i; the first one is disabled while rst_ni is low.
`ifndef BYTE_DISTRIBUTION_TO_BIT_PREDICTOR_TOP_ASSERT_SVH
`define BYTE_DISTRIBUTION_TO_BIT_PREDICTOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define BDBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BDBP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BDBP_ASSERT(lbl, prop, msg)
`define BDBP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hdl/bdbp_pkg.sv
package bdbp_pkg;

  localparam int unsigned SYMBOLS_DEF   = 256;
  localparam int unsigned PROB_BITS_DEF = 16;

  // Prefix sums wrap at this width.
  localparam int unsigned SUM_W     = 24;
  localparam int unsigned PROB_IN_W = 16;
  // Quotient bits of the Q0.16 prediction.
  localparam int unsigned Q_W       = 16;
  localparam int unsigned Q_CNT_W   = $clog2(Q_W);

  localparam int unsigned IN_W  = 40;
  localparam int unsigned OUT_W = 56;

  localparam logic [8:0] NO_GUESS = 9'd256;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_RD_TOP  = 8'b0000_0010,
    ST_RD_MID  = 8'b0000_0100,
    ST_RD_BOT  = 8'b0000_1000,
    ST_GET_MID = 8'b0001_0000,
    ST_GET_BOT = 8'b0010_0000,
    ST_DIV     = 8'b0100_0000,
    ST_DONE    = 8'b1000_0000
  } bdbp_state_e;

endpackage

// File: hdl/bdbp_ram.sv
module bdbp_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/byte_distribution_to_bit_predictor_top.sv
// Load beats (op 0) without last give no result; the block stays ready for the next beat.
// A bit beat, or a load beat with last, gives its result beat after three reads of the prefix
// RAM, the two differences, a radix-2 divider with one quotient bit per cycle for 16 bits and
// an output state, which a stalled result extends.
// A zero denominator or saturating ratio skips the divider; a new beat is taken after the result.
// Reset is asynchronous, active low; a fill count makes unloaded prefix sums read as the final sum.
module byte_distribution_to_bit_predictor_top
  import bdbp_pkg::*;
#(
  parameter int unsigned SYMBOLS   = SYMBOLS_DEF,
  parameter int unsigned PROB_BITS = PROB_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // prob[15:0], new_bit[16], ppm_guess[25:17], partial_byte[33:26],
  // ppm_expected_bit[34], zero fill[39:35]
  input  logic [IN_W-1:0]  s_axis_tdata,
  // op[0]
  input  logic             s_axis_tuser,
  input  logic             s_axis_tlast,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // prediction_valid[0], bit_probability[16:1], likely_bit[17], argmax_byte[25:18],
  // agreement_ctx[34:26], bit_ctx_out[43:35], bit_agree_ctx[53:44], zero fill[55:54]
  output logic [OUT_W-1:0] m_axis_tdata
);

`include "byte_distribution_to_bit_predictor_top_assert.svh"

  localparam int unsigned IDX_W = $clog2(SYMBOLS);
  localparam int unsigned CNT_W = $clog2(SYMBOLS + 1);
  localparam int unsigned PW    = (PROB_BITS < PROB_IN_W) ? PROB_BITS : PROB_IN_W;

  bdbp_state_e state_q, state_d;

  logic [CNT_W-1:0] load_idx_q, load_idx_d;
  logic [SUM_W-1:0] run_sum_q, run_sum_d;
  logic [PW-1:0]    best_prob_q, best_prob_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  logic [8:0]       agree_q, agree_d;
  logic [IDX_W-1:0] top_q, top_d, bot_q, bot_d, mid_q, mid_d;
  logic [CNT_W-1:0] mem_cnt_q, mem_cnt_d;
  logic [SUM_W-1:0] tail_q, tail_d;
  logic [Q_W-1:0]   hold_prob_q, hold_prob_d;
  logic             hold_e_q, hold_e_d;
  logic [8:0]       hold_bctx_q, hold_bctx_d;
  logic [9:0]       hold_actx_q, hold_actx_d;
  logic             rd_tail_q, rd_tail_d, rd_zero_q, rd_zero_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic             pvalid_q, pvalid_d;
  logic             m_valid_q, m_valid_d;

  // Payload registers without reset.
  logic [7:0]       part_q, part_d;
  logic             ppm_q, ppm_d;
  logic [SUM_W-1:0] s_top_q, s_top_d, num_q, num_d, den_q, den_d, rem_q, rem_d;
  logic [Q_W-1:0]   quo_q, quo_d;
  logic [OUT_W-1:0] m_data_q, m_data_d;

  // Input fields.
  logic             in_acc;
  logic [PW-1:0]    prob_m;
  logic             bit_in, ppmb_in;
  logic [8:0]       guess_in;
  logic [7:0]       part_in;

  logic             load_ok, first;
  logic [SUM_W-1:0] sum_base, sum_new, ld_sum;
  logic [PW-1:0]    bp_base;
  logic [IDX_W-1:0] bi_base, bi_new, ld_bi;
  logic             gt;
  logic [CNT_W-1:0] idx_inc, ld_cnt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_raddr, bot_dec;
  logic [SUM_W-1:0] ram_rdata, rd_val, den_c;
  logic [SUM_W:0]   rem2;
  logic             ge;
  logic             out_free;
  logic [Q_W-1:0]   o_prob;
  logic             o_e;
  logic [8:0]       o_bctx;
  logic [9:0]       o_actx;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign prob_m   = s_axis_tdata[PW-1:0];
  assign bit_in   = s_axis_tdata[16];
  assign guess_in = s_axis_tdata[25:17];
  assign part_in  = s_axis_tdata[33:26];
  assign ppmb_in  = s_axis_tdata[34];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign out_free      = !m_valid_q || m_axis_tready;

  // The first element of a distribution starts the sum and the argmax afresh.
  assign load_ok  = load_idx_q < CNT_W'(SYMBOLS);
  assign first    = (load_idx_q == '0);
  assign sum_base = first ? '0 : run_sum_q;
  assign bp_base  = first ? '0 : best_prob_q;
  assign bi_base  = first ? '0 : best_idx_q;
  assign sum_new  = sum_base + SUM_W'(prob_m);
  assign gt       = prob_m > bp_base;
  assign bi_new   = gt ? load_idx_q[IDX_W-1:0] : bi_base;
  assign idx_inc  = load_idx_q + 1'b1;
  assign ld_cnt   = load_ok ? idx_inc : load_idx_q;
  assign ld_sum   = load_ok ? sum_new : run_sum_q;
  assign ld_bi    = load_ok ? bi_new : best_idx_q;

  assign ram_we   = in_acc && !s_axis_tuser && load_ok;
  assign bot_dec  = bot_q - 1'b1;

  // Entries beyond the fill count hold the final sum of the last distribution.
  assign rd_val = rd_zero_q ? '0 : (rd_tail_q ? tail_q : ram_rdata);
  assign den_c  = s_top_q - rd_val;

  assign rem2 = {rem_q, 1'b0};
  assign ge   = rem2 >= {1'b0, den_q};

  assign o_e    = quo_q[Q_W-1];
  assign o_prob = pvalid_q ? quo_q : hold_prob_q;
  assign o_bctx = pvalid_q ? {o_e, part_q} : hold_bctx_q;
  assign o_actx = pvalid_q ? {ppm_q, o_e, part_q} : hold_actx_q;

  bdbp_ram #(
    .WIDTH (SUM_W),
    .DEPTH (SYMBOLS)
  ) u_prefix_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (load_idx_q[IDX_W-1:0]),
    .wdata_i (sum_new),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    load_idx_d  = load_idx_q;
    run_sum_d   = run_sum_q;
    best_prob_d = best_prob_q;
    best_idx_d  = best_idx_q;
    agree_d     = agree_q;
    top_d       = top_q;
    bot_d       = bot_q;
    mid_d       = mid_q;
    mem_cnt_d   = mem_cnt_q;
    tail_d      = tail_q;
    hold_prob_d = hold_prob_q;
    hold_e_d    = hold_e_q;
    hold_bctx_d = hold_bctx_q;
    hold_actx_d = hold_actx_q;
    rd_tail_d   = 1'b0;
    rd_zero_d   = 1'b0;
    cnt_d       = cnt_q;
    pvalid_d    = pvalid_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    part_d      = part_q;
    ppm_d       = ppm_q;
    s_top_d     = s_top_q;
    num_d       = num_q;
    den_d       = den_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    m_data_d    = m_data_q;
    ram_raddr   = top_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          part_d = part_in;
          ppm_d  = ppmb_in;
          if (!s_axis_tuser) begin
            if (load_ok) begin
              run_sum_d   = sum_new;
              best_prob_d = gt ? prob_m : bp_base;
              best_idx_d  = bi_new;
              load_idx_d  = idx_inc;
              mem_cnt_d   = (idx_inc > mem_cnt_q) ? idx_inc : mem_cnt_q;
            end
            if (s_axis_tlast) begin
              mem_cnt_d   = ld_cnt;
              tail_d      = ld_sum;
              agree_d     = (9'(ld_bi) == guess_in) ? 9'(ld_bi) : NO_GUESS;
              load_idx_d  = '0;
              run_sum_d   = '0;
              best_prob_d = '0;
              top_d       = IDX_W'(SYMBOLS - 1);
              bot_d       = '0;
              state_d     = ST_RD_TOP;
            end
          end else begin
            // A one keeps the upper half unless the range is a single byte.
            if (bit_in) begin
              if (mid_q < top_q) begin
                bot_d = mid_q + 1'b1;
              end
            end else begin
              top_d = mid_q;
            end
            state_d = ST_RD_TOP;
          end
        end
      end
      ST_RD_TOP: begin
        mid_d     = bot_q + IDX_W'((top_q - bot_q) >> 1);
        ram_raddr = top_q;
        rd_tail_d = !(CNT_W'(top_q) < mem_cnt_q);
        state_d   = ST_RD_MID;
      end
      ST_RD_MID: begin
        ram_raddr = mid_q;
        rd_tail_d = !(CNT_W'(mid_q) < mem_cnt_q);
        s_top_d   = rd_val;
        state_d   = ST_RD_BOT;
      end
      ST_RD_BOT: begin
        ram_raddr = bot_dec;
        rd_tail_d = !(CNT_W'(bot_dec) < mem_cnt_q);
        rd_zero_d = (bot_q == '0);
        num_d     = s_top_q - rd_val;
        state_d   = ST_GET_MID;
      end
      ST_GET_MID: begin
        den_d   = den_c;
        state_d = ST_GET_BOT;
      end
      ST_GET_BOT: begin
        rem_d = num_q;
        quo_d = '0;
        cnt_d = '0;
        priority if (den_q == '0) begin
          pvalid_d = 1'b0;
          state_d  = ST_DONE;
        end else if (num_q >= den_q) begin
          // A ratio of one or more saturates.
          pvalid_d = 1'b1;
          quo_d    = '1;
          state_d  = ST_DONE;
        end else begin
          pvalid_d = 1'b1;
          state_d  = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = ge ? SUM_W'(rem2 - {1'b0, den_q}) : rem2[SUM_W-1:0];
        quo_d = {quo_q[Q_W-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == Q_CNT_W'(Q_W - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          hold_prob_d = o_prob;
          hold_e_d    = pvalid_q ? o_e : hold_e_q;
          hold_bctx_d = o_bctx;
          hold_actx_d = o_actx;
          m_data_d    = {2'b00, o_actx, o_bctx, agree_q, 8'(best_idx_q),
                         (pvalid_q ? o_e : hold_e_q), o_prob, pvalid_q};
          m_valid_d   = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      load_idx_q  <= '0;
      run_sum_q   <= '0;
      best_prob_q <= '0;
      best_idx_q  <= '0;
      agree_q     <= NO_GUESS;
      top_q       <= IDX_W'(SYMBOLS - 1);
      bot_q       <= '0;
      mid_q       <= IDX_W'((SYMBOLS - 1) / 2);
      mem_cnt_q   <= '0;
      tail_q      <= '0;
      hold_prob_q <= '0;
      hold_e_q    <= 1'b0;
      hold_bctx_q <= '0;
      hold_actx_q <= '0;
      rd_tail_q   <= 1'b0;
      rd_zero_q   <= 1'b0;
      cnt_q       <= '0;
      pvalid_q    <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_idx_q  <= load_idx_d;
      run_sum_q   <= run_sum_d;
      best_prob_q <= best_prob_d;
      best_idx_q  <= best_idx_d;
      agree_q     <= agree_d;
      top_q       <= top_d;
      bot_q       <= bot_d;
      mid_q       <= mid_d;
      mem_cnt_q   <= mem_cnt_d;
      tail_q      <= tail_d;
      hold_prob_q <= hold_prob_d;
      hold_e_q    <= hold_e_d;
      hold_bctx_q <= hold_bctx_d;
      hold_actx_q <= hold_actx_d;
      rd_tail_q   <= rd_tail_d;
      rd_zero_q   <= rd_zero_d;
      cnt_q       <= cnt_d;
      pvalid_q    <= pvalid_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    part_q   <= part_d;
    ppm_q    <= ppm_d;
    s_top_q  <= s_top_d;
    num_q    <= num_d;
    den_q    <= den_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    m_data_q <= m_data_d;
  end

  `BDBP_ASSERT(a_rem_below_den, (state_q == ST_DIV) |-> (rem_q < den_q), "remainder too big")
  `BDBP_ASSERT(a_range_ordered, bot_q <= top_q, "byte range bottom above top")
  `BDBP_ASSERT(a_fill_bounded, mem_cnt_q <= CNT_W'(SYMBOLS), "fill count beyond alphabet")
  `BDBP_ASSERT(a_done_emits, (state_q == ST_DONE && out_free) |=> m_axis_tvalid, "no result")

endmodule
